>>> rtl/core/bdq_pkg.sv
// Shared types and constants for the bounded deque.
// Depends on nothing; every other file in rtl/core imports it.
`timescale 1ns / 1ps

package bdq_pkg;

  localparam int DEPTH      = 256;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CAP_W      = 9;
  localparam int CMP_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // What one chain does in a cycle. INSERT shifts towards the far end and
  // loads the new value into cell 0; REMOVE shifts towards cell 0; APPEND
  // loads the new value into the cell just past the last one in use.
  typedef enum logic [1:0] {
    CH_HOLD   = 2'd0,
    CH_INSERT = 2'd1,
    CH_REMOVE = 2'd2,
    CH_APPEND = 2'd3
  } chain_op_t;

  typedef struct packed {
    chain_op_t op;
    logic      sel;
  } cell_ctrl_t;

endpackage

>>> rtl/core/bdq_cell.sv
// One storage cell of a deque chain: holds an entry, takes from either
// neighbour or from the request value. Depends on bdq_pkg.
`timescale 1ns / 1ps

module bdq_cell (
  input  logic                           clk,
  input  bdq_pkg::cell_ctrl_t            ctrl,
  input  logic [bdq_pkg::DATA_WIDTH-1:0] value,
  input  logic [bdq_pkg::DATA_WIDTH-1:0] lower,
  input  logic [bdq_pkg::DATA_WIDTH-1:0] upper,
  output logic [bdq_pkg::DATA_WIDTH-1:0] q
);
  import bdq_pkg::*;

  logic [DATA_WIDTH-1:0] q_next;

  always_comb begin
    q_next = q;
    unique case (ctrl.op)
      CH_HOLD:   q_next = q;
      CH_INSERT: q_next = lower;
      CH_REMOVE: q_next = upper;
      CH_APPEND: if (ctrl.sel) q_next = value;
      default:   q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

>>> rtl/core/bdq_chain.sv
// A row of DEPTH deque cells with its end held at cell 0.
// Depends on bdq_pkg and bdq_cell.
`timescale 1ns / 1ps

module bdq_chain (
  input  logic                           clk,
  input  bdq_pkg::chain_op_t             op,
  input  logic [bdq_pkg::CNT_W-1:0]      occ,
  input  logic [bdq_pkg::DATA_WIDTH-1:0] value,
  output logic [bdq_pkg::DATA_WIDTH-1:0] head
);
  import bdq_pkg::*;

  logic [DATA_WIDTH-1:0] q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctrl_t            ctrl;
    logic [DATA_WIDTH-1:0] lower;
    logic [DATA_WIDTH-1:0] upper;

    assign ctrl = '{op: op, sel: (occ == CNT_W'(i))};

    if (i == 0) begin : g_first
      assign lower = value;
    end else begin : g_mid_lo
      assign lower = q[i-1];
    end

    // the last cell takes nothing useful from above: it leaves use first
    if (i == DEPTH - 1) begin : g_last
      assign upper = value;
    end else begin : g_mid_hi
      assign upper = q[i+1];
    end

    bdq_cell u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .value (value),
      .lower (lower),
      .upper (upper),
      .q     (q[i])
    );
  end

  assign head = q[0];

endmodule

>>> rtl/core/bounded_deque.sv
// Bounded double-ended queue built from two chains of cells: one holds the
// entries front first, the other back first, so both ends sit at cell 0.
// The result is registered, out in the cycle after the request is taken;
// one request per cycle unless stalled; chains and count update together.
// Synchronous reset empties the queue and sets capacity to 256; the cells
// themselves are not cleared, the count alone marks which hold entries.
`timescale 1ns / 1ps

module bounded_deque (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [8:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic signed [31:0] data,
  output logic [8:0]         count
);
  import bdq_pkg::*;

  logic [CAP_W-1:0]      capacity;
  logic [CNT_W-1:0]      occ;
  logic [CNT_W-1:0]      occ_next;
  logic                  accept;
  logic                  full;
  logic                  empty;
  logic [DATA_WIDTH-1:0] val;
  logic [DATA_WIDTH-1:0] front_q;
  logic [DATA_WIDTH-1:0] back_q;
  chain_op_t             op_fwd;
  chain_op_t             op_rev;
  status_t               res_status;
  logic [DATA_WIDTH-1:0] res_data;
  status_t               status_r;
  logic [DATA_WIDTH-1:0] data_r;
  logic [CNT_W-1:0]      count_r;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign val      = value[DATA_WIDTH-1:0];

  assign full  = (CMP_W'(occ) >= CMP_W'(capacity)) || (occ == CNT_W'(DEPTH));
  assign empty = (occ == '0);

  always_comb begin
    op_fwd     = CH_HOLD;
    op_rev     = CH_HOLD;
    res_status = ST_DONE;
    res_data   = '0;
    occ_next   = occ;
    if (accept) begin
      unique case (cmd_t'(cmd))
        CMD_PUSH_FRONT: begin
          if (full) begin
            res_status = ST_FULL;
          end else begin
            op_fwd   = CH_INSERT;
            op_rev   = CH_APPEND;
            res_data = val;
            occ_next = occ + 1'b1;
          end
        end
        CMD_PUSH_BACK: begin
          if (full) begin
            res_status = ST_FULL;
          end else begin
            op_fwd   = CH_APPEND;
            op_rev   = CH_INSERT;
            res_data = val;
            occ_next = occ + 1'b1;
          end
        end
        CMD_POP_FRONT: begin
          if (empty) begin
            res_status = ST_EMPTY;
          end else begin
            // the reversed chain just drops its last cell in use
            op_fwd   = CH_REMOVE;
            res_data = front_q;
            occ_next = occ - 1'b1;
          end
        end
        CMD_POP_BACK: begin
          if (empty) begin
            res_status = ST_EMPTY;
          end else begin
            op_rev   = CH_REMOVE;
            res_data = back_q;
            occ_next = occ - 1'b1;
          end
        end
        default: res_status = ST_DONE;
      endcase
    end
  end

  bdq_chain u_fwd (
    .clk   (clk),
    .op    (op_fwd),
    .occ   (occ),
    .value (val),
    .head  (front_q)
  );

  bdq_chain u_rev (
    .clk   (clk),
    .op    (op_rev),
    .occ   (occ),
    .value (val),
    .head  (back_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAP_RESET;
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) capacity <= cfg_data;
      occ <= occ_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // hold the result until it is taken
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= res_status;
      data_r   <= res_data;
      count_r  <= occ_next;
    end
  end

  assign status = status_r;
  assign data   = signed'(32'(data_r));
  assign count  = 9'(count_r);

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CNT_W'(DEPTH))
    else $error("entry count above storage depth");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_DONE) |-> (data == 0))
    else $error("refused request returned non-zero data");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    accept && !full && (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK)
      |=> (occ == $past(occ) + 1'b1) && (count == 9'($past(occ) + 1'b1)))
    else $error("push did not advance the entry count");

  a_refused_count: assert property (@(posedge clk) disable iff (rst)
    accept && ((full && (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK)) ||
               (empty && (cmd == CMD_POP_FRONT || cmd == CMD_POP_BACK)))
      |=> $stable(occ) && (status != ST_DONE))
    else $error("refused request changed the entry count");

endmodule
